@@ design/trm_pkg.sv @@
package trm_pkg;

	localparam int KMERS_PER_REGION = 6;
	localparam int MIN_K            = 2;
	localparam int MAX_K            = 5;
	localparam int THR_RESET        = 5;
	localparam int NUM_K            = MAX_K - MIN_K + 1;

	// A position is judged once the base LOOKAHEAD places to its right has arrived.
	localparam int LOOKAHEAD = KMERS_PER_REGION * MAX_K + MAX_K - 2;
	localparam int REACH     = LOOKAHEAD + 1;
	localparam int WIN_LEN   = 2 * LOOKAHEAD + 2;
	localparam int CENTER    = LOOKAHEAD;
	localparam int REACH_W   = $clog2(REACH + 1);

	localparam int POS_W  = 32;
	localparam int THR_W  = 3;
	localparam int CNT_W  = $clog2(KMERS_PER_REGION + 1);
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Register indexes on the configuration port.
	localparam logic REG_CHECK_ENABLE     = 1'b0;
	localparam logic REG_REPEAT_THRESHOLD = 1'b1;

	typedef struct packed {
		logic [1:0] base;
		logic       seq_end;
	} trm_in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             masked;
		logic [POS_W-1:0] masked_total;
		logic             final_result;
	} trm_out_t;

	typedef struct packed {
		logic             check_enable;
		logic [THR_W-1:0] repeat_threshold;
	} trm_cfg_t;

	// One classified base on its way from the front to the back.
	typedef struct packed {
		logic [1:0]         base;
		logic               fin;
		logic               emit;
		logic [REACH_W-1:0] lag;
	} trm_slot_t;

endpackage

@@ design/tandem_repeat_masker.sv @@
// Tandem repeat masker. Bases enter on the base channel (base_valid, base_ready,
// base_item), one 2-bit code per transfer, with seq_end set on the last base of
// a sequence. Each position comes back on the res channel as one transfer with
// its index, its mask bit, the running masked total and a last-position flag.
// The judgement of a position needs the 33 bases after it, so position p is
// delivered at the earliest once base p+33 has passed the queue, the window and
// the s1, s2 and s3 registers; the end-of-sequence base flushes all pending positions.
// Throughput is one base per cycle unless results back up or a flush runs. A
// sequence end occupies the judging back end while it shifts padding through its
// 68-base window, while the input queue takes bases of the next sequence till full.
// The registers sit on an APB port: check_enable at 0x0, repeat_threshold at 0x4;
// they are to be written only while the block is idle; the block does not enforce this.
// Reset clears all counters, empties the queue and the result stage, disables
// checking and sets the threshold to five. A stalled receiver holds the result
// register; the back end then stops, the 4-entry queue fills and base_ready falls.
module tandem_repeat_masker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        base_valid,
	output logic                        base_ready,
	input  trm_pkg::trm_in_t            base_item,
	output logic                        res_valid,
	input  logic                        res_ready,
	output trm_pkg::trm_out_t           res_item,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [trm_pkg::ADDR_W-1:0]  paddr,
	input  logic [trm_pkg::DATA_W-1:0]  pwdata,
	output logic [trm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import trm_pkg::*;

	trm_cfg_t  cfg_q;
	logic      wr_en;
	logic      push;
	logic      q_full;
	logic      pop;
	logic      avail;
	trm_slot_t wr_slot;
	trm_slot_t rd_slot;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_enable     <= 1'b0;
			cfg_q.repeat_threshold <= THR_W'(THR_RESET);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CHECK_ENABLE: begin
					cfg_q.check_enable <= pwdata[0];
				end
				REG_REPEAT_THRESHOLD: begin
					cfg_q.repeat_threshold <= pwdata[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CHECK_ENABLE: begin
				prdata = DATA_W'(cfg_q.check_enable);
			end
			REG_REPEAT_THRESHOLD: begin
				prdata = DATA_W'(cfg_q.repeat_threshold);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	trm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_valid (base_valid),
		.base_ready (base_ready),
		.base_item  (base_item),
		.q_full     (q_full),
		.push       (push),
		.slot       (wr_slot)
	);

	trm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_slot (wr_slot),
		.full    (q_full),
		.pop     (pop),
		.avail   (avail),
		.rd_slot (rd_slot)
	);

	trm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.slot_avail (avail),
		.slot_head  (rd_slot),
		.slot_pop   (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

endmodule

@@ design/trm_front.sv @@
module trm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               base_valid,
	output logic               base_ready,
	input  trm_pkg::trm_in_t   base_item,
	input  logic               q_full,
	output logic               push,
	output trm_pkg::trm_slot_t slot
);
	import trm_pkg::*;

	// Number of received bases of this sequence that are not yet judged.
	logic [REACH_W-1:0] lag_q;
	logic [REACH_W-1:0] lag_next;
	logic               emit;

	assign lag_next   = lag_q + REACH_W'(1);
	assign emit       = (lag_next == REACH_W'(REACH));
	assign base_ready = !q_full;
	assign push       = base_valid && !q_full;

	always_comb begin
		slot.base = base_item.base;
		slot.fin  = base_item.seq_end;
		slot.emit = emit;
		slot.lag  = lag_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q <= '0;
		end else if (push) begin
			if (base_item.seq_end) begin
				lag_q <= '0;
			end else if (emit) begin
				lag_q <= REACH_W'(LOOKAHEAD);
			end else begin
				lag_q <= lag_next;
			end
		end
	end

endmodule

@@ design/trm_fifo.sv @@
module trm_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  trm_pkg::trm_slot_t wr_slot,
	output logic               full,
	input  logic               pop,
	output logic               avail,
	output trm_pkg::trm_slot_t rd_slot
);
	import trm_pkg::*;

	trm_slot_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;

	assign full    = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign avail   = (count_q != '0);
	assign rd_slot = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_slot;
		end
	end

endmodule

@@ design/trm_back.sv @@
module trm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  trm_pkg::trm_cfg_t  cfg,
	input  logic               slot_avail,
	input  trm_pkg::trm_slot_t slot_head,
	output logic               slot_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output trm_pkg::trm_out_t  res_item
);
	import trm_pkg::*;

	// True when some k-mer of a region occurs at least thr times.
	function automatic logic repeat_hit(
		input logic [KMERS_PER_REGION-1:0][KMERS_PER_REGION-1:0] eq,
		input logic [THR_W-1:0]                                 thr
	);
		logic [CNT_W-1:0] cnt;
		logic             hit;
		hit = 1'b0;
		for (int c = 0; c < KMERS_PER_REGION; c++) begin
			cnt = CNT_W'(1);
			for (int e = 0; e < KMERS_PER_REGION; e++) begin
				if (e < c) begin
					cnt = cnt + CNT_W'(eq[e][c]);
				end else if (e > c) begin
					cnt = cnt + CNT_W'(eq[c][e]);
				end
			end
			if (32'(cnt) >= 32'(thr)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	logic                  flush_q;
	logic [REACH_W-1:0]    dummy_q;
	logic [REACH_W-1:0]    tail_lag_q;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      masked_cnt_q;
	logic [1:0]            win_q [WIN_LEN];

	logic                  v_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [REACH_W-1:0]    rem_s1;
	logic                  final_s1;
	logic                  v_s2;
	logic [POS_W-1:0]      pos_s2;
	logic                  final_s2;
	logic                  v_s3;
	trm_out_t              res_s3;

	logic                  take_s3;
	logic                  load_s2;
	logic                  load_s1;
	logic                  slot_ok;
	logic                  slot_emit;
	logic                  slot_final;
	logic [1:0]            slot_base;
	logic [REACH_W-1:0]    slot_rem;
	logic [REACH_W:0]      lag_sum;
	logic                  fire;
	logic [NUM_K-1:0][MAX_K-1:0][1:0] hit_rl;
	logic                  masked_s2;
	logic [POS_W-1:0]      total_next;

	assign take_s3 = !v_s3 || res_ready;
	assign load_s2 = !v_s2 || take_s3;
	assign load_s1 = !v_s1 || load_s2;

	// Every slot shifts one symbol into the window, so the judged position always
	// sits at the center tap. After the last base, zero padding is shifted in and
	// the pending positions are judged as they reach the center.
	always_comb begin
		lag_sum = {1'b0, dummy_q} + {1'b0, tail_lag_q};
		if (flush_q) begin
			slot_ok    = 1'b1;
			slot_base  = 2'b00;
			slot_emit  = (lag_sum >= (REACH_W + 1)'(REACH));
			slot_final = (dummy_q == REACH_W'(LOOKAHEAD));
			slot_rem   = REACH_W'(REACH) - dummy_q;
		end else begin
			slot_ok    = slot_avail;
			slot_base  = slot_head.base;
			slot_emit  = slot_head.emit;
			slot_final = 1'b0;
			slot_rem   = REACH_W'(REACH);
		end
	end

	assign fire     = slot_ok && load_s1;
	assign slot_pop = fire && !flush_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q      <= 1'b0;
			dummy_q      <= '0;
			tail_lag_q   <= '0;
			pos_q        <= '0;
			masked_cnt_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
		end else begin
			if (fire) begin
				if (flush_q) begin
					dummy_q <= dummy_q + REACH_W'(1);
					if (slot_final) begin
						flush_q <= 1'b0;
					end
				end else if (slot_head.fin) begin
					flush_q    <= 1'b1;
					dummy_q    <= REACH_W'(1);
					tail_lag_q <= slot_head.lag;
				end
				if (slot_emit) begin
					pos_q <= slot_final ? '0 : pos_q + POS_W'(1);
				end
			end
			if (load_s1) begin
				v_s1 <= fire && slot_emit;
			end
			if (load_s2) begin
				v_s2 <= v_s1;
			end
			if (take_s3) begin
				v_s3 <= v_s2;
				if (v_s2) begin
					masked_cnt_q <= final_s2 ? '0 : total_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			win_q[0] <= slot_base;
			for (int i = 1; i < WIN_LEN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
		if (load_s1) begin
			pos_s1   <= pos_q;
			rem_s1   <= slot_rem;
			final_s1 <= slot_final;
		end
		if (load_s2) begin
			pos_s2   <= pos_s1;
			final_s2 <= final_s1;
		end
		if (take_s3) begin
			res_s3.position     <= pos_s2;
			res_s3.masked       <= masked_s2;
			res_s3.masked_total <= total_next;
			res_s3.final_result <= final_s2;
		end
	end

	// One comparison block per k and shift, each holding a right and a left region.
	for (genvar ki = 0; ki < NUM_K; ki++) begin : g_k
		for (genvar s = 0; s < MAX_K; s++) begin : g_s
			if (s < MIN_K + ki) begin : g_on
				localparam int K = MIN_K + ki;
				localparam logic [REACH_W-1:0] SPAN = REACH_W'(KMERS_PER_REGION * K + s);

				logic [2*MAX_K-1:0] rchunk [KMERS_PER_REGION];
				logic [2*MAX_K-1:0] lchunk [KMERS_PER_REGION];
				logic [KMERS_PER_REGION-1:0][KMERS_PER_REGION-1:0] req;
				logic [KMERS_PER_REGION-1:0][KMERS_PER_REGION-1:0] leq;
				logic [KMERS_PER_REGION-1:0][KMERS_PER_REGION-1:0] req_s2;
				logic [KMERS_PER_REGION-1:0][KMERS_PER_REGION-1:0] leq_s2;
				logic rok_s2;
				logic lok_s2;

				for (genvar c = 0; c < KMERS_PER_REGION; c++) begin : g_c
					for (genvar j = 0; j < MAX_K; j++) begin : g_j
						if (j < K) begin : g_tap
							assign rchunk[c][2*j +: 2] = win_q[CENTER - s - c*K - j];
							assign lchunk[c][2*j +: 2] = win_q[CENTER + 1 + s + c*K + j];
						end else begin : g_pad
							assign rchunk[c][2*j +: 2] = 2'b00;
							assign lchunk[c][2*j +: 2] = 2'b00;
						end
					end
				end

				for (genvar a = 0; a < KMERS_PER_REGION; a++) begin : g_a
					for (genvar b = 0; b < KMERS_PER_REGION; b++) begin : g_b
						if (a < b) begin : g_cmp
							assign req[a][b] = (rchunk[a] == rchunk[b]);
							assign leq[a][b] = (lchunk[a] == lchunk[b]);
						end else begin : g_zero
							assign req[a][b] = 1'b0;
							assign leq[a][b] = 1'b0;
						end
					end
				end

				always_ff @(posedge clk) begin
					if (load_s2) begin
						req_s2 <= req;
						leq_s2 <= leq;
						rok_s2 <= (SPAN <= rem_s1);
						lok_s2 <= (pos_s1[POS_W-1:REACH_W] != '0) ||
							(pos_s1[REACH_W-1:0] >= SPAN);
					end
				end

				assign hit_rl[ki][s] = {
					rok_s2 && repeat_hit(req_s2, cfg.repeat_threshold),
					lok_s2 && repeat_hit(leq_s2, cfg.repeat_threshold)
				};
			end else begin : g_off
				assign hit_rl[ki][s] = 2'b00;
			end
		end
	end

	assign masked_s2  = cfg.check_enable && (|hit_rl);
	assign total_next = (masked_s2 && (masked_cnt_q != '1)) ?
		masked_cnt_q + POS_W'(1) : masked_cnt_q;

	assign res_valid = v_s3;
	assign res_item  = res_s3;

endmodule

@@ dv/tb_tandem_repeat_masker.sv @@
module tb_tandem_repeat_masker;
	import trm_pkg::*;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;
	localparam int PHASES = 10;
	localparam int PHASE_QUOTA = 33;
	localparam int RING_AW = $clog2(WIN_LEN);

	logic              clk;
	logic              arst_n = 1'b0;
	logic              base_valid = 1'b0;
	logic              base_ready;
	trm_in_t           base_item = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	trm_out_t          res_item;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Mirror of the block: recent bases, sequence counters and register values.
	logic [1:0]  ring [WIN_LEN];
	int          ring_head = 0;
	logic [31:0] bases_seen = '0;
	logic [31:0] next_position = '0;
	logic [31:0] masked_so_far = '0;
	bit          check_on = 1'b0;
	logic [2:0]  thr = 3'd5;

	trm_in_t  bases_to_send [$];
	trm_out_t judgements_due [$];
	trm_out_t due_now;
	int       bases_queued = 0;
	int       bases_taken = 0;
	int       fail_count = 0;
	int       send_wait = 0;
	int       recv_wait = 0;
	bit       send_burst = 1'b0;
	bit       recv_burst = 1'b0;
	bit       base_held;

	bit en_plan [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1, 1, 1};
	int thr_plan [PHASES] = '{5, 0, 7, 2, 1, 6, 3, 4, 2, 3};

	tandem_repeat_masker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.base_valid(base_valid),
		.base_ready(base_ready),
		.base_item(base_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [1:0] stored_base(logic [31:0] q);
		logic [31:0] d;
		d = (bases_seen - 1) - q;
		if (d >= WIN_LEN)
			return 2'b00;
		return ring[RING_AW'((ring_head + WIN_LEN - 1 - d) % WIN_LEN)];
	endfunction

	function automatic bit region_has_repeat(logic [31:0] start, bit forward, int k);
		logic [2*MAX_K-1:0] words [KMERS_PER_REGION];
		logic [31:0] q;
		int hits, best;
		best = 0;
		for (int c = 0; c < KMERS_PER_REGION; c++) begin
			words[c] = '0;
			for (int j = 0; j < k; j++) begin
				q = forward ? start + c * k + j : start - c * k - j;
				words[c] = {words[c][2*MAX_K-3:0], stored_base(q)};
			end
		end
		for (int c = 0; c < KMERS_PER_REGION; c++) begin
			hits = 0;
			for (int e = 0; e < KMERS_PER_REGION; e++)
				if (words[e] == words[c])
					hits++;
			if (hits > best)
				best = hits;
		end
		return best >= thr;
	endfunction

	// Regions that would run off either end of the sequence end the search
	// for that direction and k.
	function automatic bit judge_position(logic [31:0] p);
		logic [31:0] ahead;
		int span;
		ahead = bases_seen - p;
		if (!check_on)
			return 1'b0;
		for (int k = MIN_K; k <= MAX_K; k++) begin
			span = k * KMERS_PER_REGION;
			for (int s = 0; s < k; s++) begin
				if (span + s > ahead)
					break;
				if (region_has_repeat(p + s, 1'b1, k))
					return 1'b1;
			end
			for (int s = 0; s < k; s++) begin
				if (span + s > p)
					break;
				if (region_has_repeat(p - s - 1, 1'b0, k))
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void judge_next(bit last);
		trm_out_t r;
		r.position = next_position;
		r.masked = judge_position(next_position);
		if (r.masked && masked_so_far != '1)
			masked_so_far++;
		r.masked_total = masked_so_far;
		r.final_result = last;
		judgements_due.push_back(r);
		next_position++;
	endfunction

	function automatic void note_base(trm_in_t it);
		int n;
		ring[RING_AW'(ring_head)] = it.base;
		ring_head = (ring_head + 1) % WIN_LEN;
		bases_seen++;
		bases_taken++;
		if (!it.seq_end) begin
			if (bases_seen - next_position > LOOKAHEAD)
				judge_next(1'b0);
		end else begin
			n = 0;
			while (next_position != bases_seen && n < LOOKAHEAD + 1) begin
				judge_next(next_position + 1 == bases_seen);
				n++;
			end
			bases_seen = '0;
			next_position = '0;
			masked_so_far = '0;
		end
	endfunction

	function automatic void put_base(logic [1:0] b, logic last);
		trm_in_t it;
		it.base = b;
		it.seq_end = last;
		bases_to_send.push_back(it);
		bases_queued++;
	endfunction

	// Mostly tandem repeats of short random units with rare point changes,
	// mixed with runs of random bases.
	function automatic void queue_sequence(int len);
		logic [1:0] unit [6];
		logic [1:0] b;
		int unit_len, run, made;
		made = 0;
		while (made < len) begin
			if ($urandom_range(0, 9) < 6) begin
				unit_len = $urandom_range(1, 6);
				for (int u = 0; u < unit_len; u++)
					unit[u] = 2'($urandom_range(0, 3));
				run = $urandom_range(6, 36);
			end else begin
				unit_len = 0;
				run = $urandom_range(1, 10);
			end
			for (int j = 0; j < run && made < len; j++) begin
				if (unit_len == 0 || $urandom_range(0, 19) == 0)
					b = 2'($urandom_range(0, 3));
				else
					b = unit[j % unit_len];
				made++;
				put_base(b, made == len);
			end
		end
	endfunction

	task automatic flag_error(string msg);
		$display("%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_CHECK_ENABLE)
			check_on = value[0];
		else
			thr = value[2:0];
	endtask

	// The pause after the last expected result covers a full window shift,
	// so the back end is idle before the next registers are written.
	task automatic settle();
		while (bases_taken != bases_queued || judgements_due.size() != 0)
			@(posedge clk);
		repeat (2 * LOOKAHEAD + 8)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid <= 1'b0;
			base_item <= '0;
			send_wait = 0;
		end else begin
			base_held = base_valid;
			if (base_valid && base_ready) begin
				note_base(base_item);
				base_held = 1'b0;
				if ($urandom_range(0, 29) == 0)
					send_burst = !send_burst;
				send_wait = send_burst ? 0 : $urandom_range(0, 11);
			end
			if (!base_held) begin
				if (send_wait == 0 && bases_to_send.size() != 0) begin
					base_item <= bases_to_send.pop_front();
					base_valid <= 1'b1;
				end else begin
					if (send_wait != 0)
						send_wait--;
					base_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (judgements_due.size() == 0) begin
					flag_error($sformatf("unexpected result transfer for position %0d",
						res_item.position));
				end else begin
					due_now = judgements_due.pop_front();
					if (res_item.position !== due_now.position
							|| res_item.masked !== due_now.masked
							|| res_item.masked_total !== due_now.masked_total
							|| res_item.final_result !== due_now.final_result)
						flag_error($sformatf({"result mismatch: expected pos %0d mask %0b ",
							"total %0d final %0b, got pos %0d mask %0b total %0d final %0b"},
							due_now.position, due_now.masked, due_now.masked_total,
							due_now.final_result, res_item.position, res_item.masked,
							res_item.masked_total, res_item.final_result));
				end
				if ($urandom_range(0, 29) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 11);
			end
			if (recv_wait != 0) begin
				recv_wait--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(20 * 300000);
		$display("[tandem_repeat_masker] ERROR");
		$finish;
	end

	initial begin
		int pick, len, random_total;
		random_total = 0;
		for (int i = 0; i < WIN_LEN; i++)
			ring[i] = 2'b00;
		arst_n = 1'b0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Checking is off after reset, so a perfect dinucleotide repeat stays clear.
		for (int i = 0; i < 12; i++)
			put_base((i % 2) ? BASE_C : BASE_A, i == 11);
		settle();
		write_reg(REG_CHECK_ENABLE, 32'd1);
		write_reg(REG_REPEAT_THRESHOLD, 32'd5);
		// A one-base sequence, then a run of one base that just fills a region.
		put_base(BASE_T, 1'b1);
		for (int i = 0; i < 12; i++)
			put_base(BASE_G, i == 11);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(REG_CHECK_ENABLE, en_plan[ph]);
			write_reg(REG_REPEAT_THRESHOLD, thr_plan[ph]);
			do begin
				pick = $urandom_range(0, 9);
				if (pick < 3)
					len = $urandom_range(1, 12);
				else if (pick < 8)
					len = $urandom_range(13, 45);
				else
					len = $urandom_range(46, 90);
				queue_sequence(len);
				random_total += len;
			end while (random_total < (ph + 1) * PHASE_QUOTA);
		end
		settle();

		if (fail_count == 0 && judgements_due.size() == 0)
			$display("[tandem_repeat_masker] OK");
		else
			$display("[tandem_repeat_masker] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
design/trm_pkg.sv
design/trm_front.sv
design/trm_fifo.sv
design/trm_back.sv
design/tandem_repeat_masker.sv
dv/tb_tandem_repeat_masker.sv
